FILE: rtl/core/lvst_pkg.sv
package lvst_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int ID_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int VOL_W = 16;
    localparam int PITCH_W = 16;
    localparam int CHAN_W = 8;
    localparam int CMD_W = 2;
    localparam int TIMER_W = 4;

    localparam logic [TIMER_W-1:0] TIMER_RELOAD = TIMER_W'(12);
    localparam logic [TIMER_W-1:0] FADE_LIMIT = TIMER_W'(7);
    localparam int FADE_DIV = 8;
    localparam int FADE_SHIFT = $clog2(FADE_DIV);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE   = 2'd0,
        CMD_START  = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_FADE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_SCAN,
        ST_REQ_DONE,
        ST_TICK_SCAN,
        ST_TICK_FLUSH
    } state_t;

    typedef struct packed {
        cmd_t                       command;
        logic [CHAN_W-1:0]          channel;
        logic [SAMPLE_W-1:0]        sample_res;
        logic signed [VOL_W-1:0]    out_left;
        logic signed [VOL_W-1:0]    out_right;
        logic [PITCH_W-1:0]         out_pitch;
        logic                       last;
    } res_t;

endpackage

FILE: rtl/core/lvst_in_if.sv
interface lvst_in_if;
    import lvst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [ID_W-1:0]            source_id;
    logic [SAMPLE_W-1:0]        sample;
    logic signed [VOL_W-1:0]    vol_left;
    logic signed [VOL_W-1:0]    vol_right;
    logic [PITCH_W-1:0]         pitch;
    logic [CHAN_W-1:0]          start_channel;

    modport source (
        output valid, operation, source_id, sample, vol_left, vol_right, pitch,
               start_channel,
        input  ready
    );

    modport sink (
        input  valid, operation, source_id, sample, vol_left, vol_right, pitch,
               start_channel,
        output ready
    );
endinterface

FILE: rtl/core/lvst_out_if.sv
interface lvst_out_if;
    import lvst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [CHAN_W-1:0]          channel;
    logic [SAMPLE_W-1:0]        sample_res;
    logic signed [VOL_W-1:0]    out_left;
    logic signed [VOL_W-1:0]    out_right;
    logic [PITCH_W-1:0]         out_pitch;
    logic                       last;

    modport source (
        output valid, command, channel, sample_res, out_left, out_right, out_pitch, last,
        input  ready
    );

    modport sink (
        input  valid, command, channel, sample_res, out_left, out_right, out_pitch, last,
        output ready
    );
endinterface

FILE: rtl/core/lvst_fade.sv
module lvst_fade (
    input  logic signed [lvst_pkg::VOL_W-1:0]   vol,
    input  logic [lvst_pkg::FADE_SHIFT-1:0]     step,
    output logic signed [lvst_pkg::VOL_W-1:0]   fade
);
    import lvst_pkg::*;

    localparam int PROD_W = VOL_W + FADE_SHIFT + 1;
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(FADE_DIV - 1);

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] shifted;

    // Division by the fade step count truncates toward zero, so negative
    // products are biased up before the arithmetic shift.
    always_comb
    begin
        prod = PROD_W'(vol) * PROD_W'($signed({1'b0, step}));
        if (prod[PROD_W-1])
        begin
            adj = prod + ROUND;
        end
        else
        begin
            adj = prod;
        end
        shifted = adj >>> FADE_SHIFT;
        fade = shifted[VOL_W-1:0];
    end
endmodule

FILE: rtl/core/looping_voice_slot_table_top.sv
// Looping voice slot table: keeps SLOT_COUNT (eight) looping-sound slots and
// takes one transaction at a time. A keep-alive request walks the slots one
// per cycle through a single id compare until it hits or reaches the last
// slot, then, in ST_REQ_DONE, writes the slot and loads the result as soon as
// the result register can take it; the next transaction is taken back in
// ST_IDLE. A tick walks every slot, one per cycle while the output side keeps
// up, through the timer decrement and one shared pair of fade multipliers,
// then releases its last result in ST_TICK_FLUSH; the walk and the flush
// pause while the result register waits to be taken.
module looping_voice_slot_table_top (
    input  logic        clk,
    input  logic        rst_n,
    lvst_in_if.sink     in_ch,
    lvst_out_if.source  out_ch
);
    import lvst_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    state_t                     state_reg, state_next;
    logic [SLOT_W-1:0]          idx_reg;

    logic [ID_W-1:0]            id_reg;
    logic [SAMPLE_W-1:0]        smp_reg;
    logic signed [VOL_W-1:0]    l_reg;
    logic signed [VOL_W-1:0]    r_reg;
    logic [PITCH_W-1:0]         pit_reg;
    logic [CHAN_W-1:0]          sch_reg;

    logic                       hit_vld_reg;
    logic                       free_vld_reg;
    logic [SLOT_W-1:0]          hit_reg;
    logic [SLOT_W-1:0]          free_reg;
    logic                       hit_play_reg;
    logic [CHAN_W-1:0]          hit_chan_reg;

    logic                       pend_vld_reg;
    res_t                       pend_reg;
    logic                       out_vld_reg;
    res_t                       out_reg;

    logic [ID_W-1:0]            src_reg   [SLOT_COUNT];
    logic [TIMER_W-1:0]         timer_reg [SLOT_COUNT];
    logic                       play_reg  [SLOT_COUNT];
    logic [CHAN_W-1:0]          chan_reg  [SLOT_COUNT];
    logic signed [VOL_W-1:0]    left_mem  [SLOT_COUNT];
    logic signed [VOL_W-1:0]    right_mem [SLOT_COUNT];

    logic                       in_take;
    logic                       push_ok;
    logic [TIMER_W-1:0]         cur_timer;
    logic [TIMER_W-1:0]         cur_dec;
    logic                       cur_live;
    logic                       cur_emit;
    logic                       cur_match;
    logic                       last_idx;
    logic                       tick_stall;
    logic                       found;
    logic                       play_eff;
    logic [SLOT_W-1:0]          sel;
    logic                       req_wr;
    logic                       tick_wr;
    logic                       out_load;
    res_t                       out_data;
    res_t                       fade_res;
    res_t                       req_res;
    logic signed [VOL_W-1:0]    fade_l;
    logic signed [VOL_W-1:0]    fade_r;

    lvst_fade u_fade_left (
        .vol  (left_mem[idx_reg]),
        .step (cur_dec[FADE_SHIFT-1:0]),
        .fade (fade_l)
    );

    lvst_fade u_fade_right (
        .vol  (right_mem[idx_reg]),
        .step (cur_dec[FADE_SHIFT-1:0]),
        .fade (fade_r)
    );

    always_comb
    begin
        in_take    = (state_reg == ST_IDLE) && in_ch.valid;
        push_ok    = !out_vld_reg || out_ch.ready;
        cur_timer  = timer_reg[idx_reg];
        cur_dec    = cur_timer - TIMER_W'(1);
        cur_live   = (cur_timer != '0);
        cur_emit   = cur_live && (cur_dec <= FADE_LIMIT);
        cur_match  = (src_reg[idx_reg] == id_reg);
        last_idx   = (idx_reg == LAST_IDX);
        tick_stall = cur_emit && pend_vld_reg && !push_ok;

        found    = hit_vld_reg || free_vld_reg;
        play_eff = hit_vld_reg && hit_play_reg;
        sel      = hit_vld_reg ? hit_reg : free_reg;

        fade_res            = '0;
        fade_res.command    = CMD_FADE;
        fade_res.channel    = chan_reg[idx_reg];
        fade_res.out_left   = fade_l;
        fade_res.out_right  = fade_r;

        req_res      = '0;
        req_res.last = 1'b1;
        if (found)
        begin
            req_res.out_left  = l_reg;
            req_res.out_right = r_reg;
            req_res.out_pitch = pit_reg;
            if (play_eff)
            begin
                req_res.command = CMD_UPDATE;
                req_res.channel = hit_chan_reg;
            end
            else
            begin
                req_res.command    = CMD_START;
                req_res.channel    = sch_reg;
                req_res.sample_res = smp_reg;
            end
        end

        req_wr   = 1'b0;
        tick_wr  = 1'b0;
        out_load = 1'b0;
        out_data = pend_reg;

        case (state_reg)
            ST_REQ_DONE:
            begin
                if (push_ok)
                begin
                    out_load = 1'b1;
                    out_data = req_res;
                    req_wr   = found;
                end
            end
            ST_TICK_SCAN:
            begin
                if (!tick_stall)
                begin
                    tick_wr  = cur_live;
                    out_load = cur_emit && pend_vld_reg;
                end
            end
            ST_TICK_FLUSH:
            begin
                if (pend_vld_reg && push_ok)
                begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (in_ch.operation == OP_TICK) ? ST_TICK_SCAN : ST_REQ_SCAN;
                end
            end
            ST_REQ_SCAN:
            begin
                if (cur_match || last_idx)
                begin
                    state_next = ST_REQ_DONE;
                end
            end
            ST_REQ_DONE:
            begin
                if (push_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_SCAN:
            begin
                if (!tick_stall && last_idx)
                begin
                    state_next = ST_TICK_FLUSH;
                end
            end
            ST_TICK_FLUSH:
            begin
                if (!pend_vld_reg || push_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            hit_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                src_reg[i]   <= '0;
                timer_reg[i] <= '0;
                play_reg[i]  <= 1'b0;
                chan_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (in_take)
            begin
                idx_reg      <= '0;
                hit_vld_reg  <= 1'b0;
                free_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_REQ_SCAN)
            begin
                if (cur_match)
                begin
                    hit_vld_reg <= 1'b1;
                end
                else if (!last_idx)
                begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                end
                if (cur_timer == '0)
                begin
                    free_vld_reg <= 1'b1;
                end
            end
            else if (state_reg == ST_TICK_SCAN && !tick_stall && !last_idx)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end

            if (state_reg == ST_TICK_SCAN && !tick_stall && cur_emit)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (state_reg == ST_TICK_FLUSH && push_ok)
            begin
                pend_vld_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (req_wr)
            begin
                src_reg[sel]   <= id_reg;
                play_reg[sel]  <= 1'b1;
                chan_reg[sel]  <= play_eff ? hit_chan_reg : sch_reg;
                timer_reg[sel] <= TIMER_RELOAD;
            end

            if (tick_wr)
            begin
                timer_reg[idx_reg] <= cur_dec;
                if (cur_dec == '0)
                begin
                    play_reg[idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            id_reg  <= in_ch.source_id;
            smp_reg <= in_ch.sample;
            l_reg   <= in_ch.vol_left;
            r_reg   <= in_ch.vol_right;
            pit_reg <= in_ch.pitch;
            sch_reg <= in_ch.start_channel;
        end
        if (state_reg == ST_REQ_SCAN)
        begin
            if (cur_match)
            begin
                hit_reg      <= idx_reg;
                hit_play_reg <= play_reg[idx_reg];
                hit_chan_reg <= chan_reg[idx_reg];
            end
            if (cur_timer == '0)
            begin
                free_reg <= idx_reg;
            end
        end
        if (state_reg == ST_TICK_SCAN && !tick_stall && cur_emit)
        begin
            pend_reg <= fade_res;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
        if (req_wr)
        begin
            left_mem[sel]  <= l_reg;
            right_mem[sel] <= r_reg;
        end
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.command    = out_reg.command;
    assign out_ch.channel    = out_reg.channel;
    assign out_ch.sample_res = out_reg.sample_res;
    assign out_ch.out_left   = out_reg.out_left;
    assign out_ch.out_right  = out_reg.out_right;
    assign out_ch.out_pitch  = out_reg.out_pitch;
    assign out_ch.last       = out_reg.last;
endmodule

FILE: rtl/core/lvst_checker.sv
module lvst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [lvst_pkg::CMD_W-1:0]       command,
    input logic [lvst_pkg::CHAN_W-1:0]      channel,
    input logic [lvst_pkg::SAMPLE_W-1:0]    sample_res,
    input logic [lvst_pkg::VOL_W-1:0]       out_left,
    input logic [lvst_pkg::VOL_W-1:0]       out_right,
    input logic [lvst_pkg::PITCH_W-1:0]     out_pitch,
    input logic                             last
);
    import lvst_pkg::*;

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command) && $stable(channel)
            && $stable(out_left) && $stable(out_right) && $stable(last))
        else $error("result changed while stalled");

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A request answers with exactly one result.
    a_req_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != CMD_FADE |-> last)
        else $error("request result not marked last");

    // Fields a command does not use read as zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (command == CMD_FADE || command == CMD_NONE)
            |-> sample_res == '0 && out_pitch == '0
                && (command == CMD_FADE || (channel == '0 && out_left == '0
                    && out_right == '0)))
        else $error("unused result field not zero");
endmodule

bind looping_voice_slot_table_top lvst_checker u_lvst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .command    (out_ch.command),
    .channel    (out_ch.channel),
    .sample_res (out_ch.sample_res),
    .out_left   (out_ch.out_left),
    .out_right  (out_ch.out_right),
    .out_pitch  (out_ch.out_pitch),
    .last       (out_ch.last)
);

FILE: bench/voice_slot_checker.sv
`timescale 1ns / 100ps

module voice_slot_checker (
    input  logic clk,
    input  logic rst_n,
    lvst_in_if   req_ch,
    lvst_out_if  res_ch,
    output int   mismatches,
    output int   pending
);
    import lvst_pkg::*;

    logic [ID_W-1:0]         slot_id   [SLOT_COUNT];
    logic [TIMER_W-1:0]      slot_life [SLOT_COUNT];
    logic                    slot_live [SLOT_COUNT];
    logic [CHAN_W-1:0]       slot_chan [SLOT_COUNT];
    logic signed [VOL_W-1:0] slot_vl   [SLOT_COUNT];
    logic signed [VOL_W-1:0] slot_vr   [SLOT_COUNT];

    res_t commands_due[$];
    int   errs = 0;

    assign mismatches = errs;

    function automatic logic signed [VOL_W-1:0] faded(logic signed [VOL_W-1:0] vol,
                                                      logic [TIMER_W-1:0] left_time);
        int prod;
        prod = int'(vol) * int'(left_time);
        return VOL_W'(prod / FADE_DIV);
    endfunction

    task automatic predict_keepalive();
        int   hit;
        int   spare;
        res_t cmd;
        hit = -1;
        spare = -1;
        for (int i = 0; i < SLOT_COUNT && hit < 0; i++)
        begin
            if (slot_life[i] == '0)
                spare = i;
            if (slot_id[i] == req_ch.source_id)
                hit = i;
        end
        if (hit < 0 && spare >= 0)
        begin
            hit = spare;
            slot_id[hit] = req_ch.source_id;
            slot_live[hit] = 1'b0;
        end
        cmd = '0;
        cmd.command = CMD_NONE;
        cmd.last = 1'b1;
        if (hit >= 0)
        begin
            if (!slot_live[hit])
            begin
                slot_live[hit] = 1'b1;
                slot_chan[hit] = req_ch.start_channel;
                cmd.command = CMD_START;
                cmd.channel = req_ch.start_channel;
                cmd.sample_res = req_ch.sample;
            end
            else
            begin
                cmd.command = CMD_UPDATE;
                cmd.channel = slot_chan[hit];
            end
            cmd.out_left = req_ch.vol_left;
            cmd.out_right = req_ch.vol_right;
            cmd.out_pitch = req_ch.pitch;
            slot_vl[hit] = req_ch.vol_left;
            slot_vr[hit] = req_ch.vol_right;
            slot_life[hit] = TIMER_RELOAD;
        end
        commands_due.push_back(cmd);
    endtask

    task automatic predict_tick();
        logic [TIMER_W-1:0] t;
        res_t               held;
        bit                 have;
        have = 1'b0;
        held = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (slot_life[i] != '0)
            begin
                t = slot_life[i] - 1'b1;
                slot_life[i] = t;
                if (t == '0)
                    slot_live[i] = 1'b0;
                if (t <= FADE_LIMIT)
                begin
                    if (have)
                        commands_due.push_back(held);
                    held = '0;
                    held.command = CMD_FADE;
                    held.channel = slot_chan[i];
                    held.out_left = faded(slot_vl[i], t);
                    held.out_right = faded(slot_vr[i], t);
                    have = 1'b1;
                end
            end
        end
        if (have)
        begin
            held.last = 1'b1;
            commands_due.push_back(held);
        end
    endtask

    task automatic field_check(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errs++;
        end
    endtask

    task automatic check_result();
        res_t want;
        if (commands_due.size() == 0)
        begin
            $error("command %0d arrived with nothing outstanding", res_ch.command);
            errs++;
            return;
        end
        want = commands_due.pop_front();
        field_check("command", 16'(want.command), 16'(res_ch.command));
        field_check("channel", 16'(want.channel), 16'(res_ch.channel));
        field_check("sample_res", want.sample_res, res_ch.sample_res);
        field_check("out_left", want.out_left, res_ch.out_left);
        field_check("out_right", want.out_right, res_ch.out_right);
        field_check("out_pitch", want.out_pitch, res_ch.out_pitch);
        field_check("last", 16'(want.last), 16'(res_ch.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_id[i] = '0;
                slot_life[i] = '0;
                slot_live[i] = 1'b0;
                slot_chan[i] = '0;
                slot_vl[i] = '0;
                slot_vr[i] = '0;
            end
            commands_due.delete();
            pending <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.operation == OP_TICK)
                    predict_tick();
                else
                    predict_keepalive();
            end
            if (res_ch.valid && res_ch.ready)
                check_result();
            pending <= commands_due.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import lvst_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int ITEMS_PER_PHASE = 26;
    localparam logic [ID_W-1:0] FILL_IDS [7] = '{16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF,
                                                 16'h5555, 16'hAAAA, 16'h1234};

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic long_hold_req = 1'b0;
    bit   long_hold_done = 1'b0;
    int   mismatches;
    int   pending;
    int   quiet_cycles = 0;

    lvst_in_if  req_if();
    lvst_out_if res_if();

    looping_voice_slot_table_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (res_if)
    );

    voice_slot_checker slot_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_ch     (req_if),
        .res_ch     (res_if),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic offer_item(input logic op, input logic [ID_W-1:0] id,
                              input logic [SAMPLE_W-1:0] smp,
                              input logic signed [VOL_W-1:0] vl, vr,
                              input logic [PITCH_W-1:0] pit, input logic [CHAN_W-1:0] ch);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.source_id <= id;
        req_if.sample <= smp;
        req_if.vol_left <= vl;
        req_if.vol_right <= vr;
        req_if.pitch <= pit;
        req_if.start_channel <= ch;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    function automatic logic signed [VOL_W-1:0] pick_volume();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            3: return 16'sd7;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_source();
        if ($urandom_range(3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(9));
    endfunction

    task automatic offer_tick();
        offer_item(OP_TICK, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), 8'($urandom()));
    endtask

    task automatic offer_keepalive(input logic [ID_W-1:0] id);
        offer_item(OP_REQUEST, id, 16'($urandom()), pick_volume(), pick_volume(),
                   16'($urandom()), 8'($urandom()));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_if.ready <= (rst_n && $urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.operation <= OP_REQUEST;
        req_if.source_id <= '0;
        req_if.sample <= '0;
        req_if.vol_left <= '0;
        req_if.vol_right <= '0;
        req_if.pitch <= '0;
        req_if.start_channel <= '0;
        tx_idle_pct = 29;
        rx_idle_pct <= 45;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty table gives a tick with no transactions, and id zero matches slot zero.
        offer_tick();
        offer_item(OP_REQUEST, 16'h0000, 16'hFFFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, 8'hFF);
        offer_item(OP_REQUEST, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh8000, 16'h0000, 8'h00);
        for (int n = 0; n < 7; n++)
            offer_keepalive(FILL_IDS[n]);
        offer_keepalive(16'h4321);
        repeat (12) offer_tick();
        offer_keepalive(16'h0001);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 45 : 0;
            rx_idle_pct <= (ph == 0) ? 45 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 0 && n == 6)
                    long_hold_req <= 1'b1;
                if ($urandom_range(99) < 38)
                    offer_tick();
                else
                    offer_keepalive(pick_source());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/lvst_pkg.sv
rtl/core/lvst_in_if.sv
rtl/core/lvst_out_if.sv
rtl/core/lvst_fade.sv
rtl/core/looping_voice_slot_table_top.sv
rtl/core/lvst_checker.sv
bench/voice_slot_checker.sv
bench/testbench.sv
